>>> rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Status codes shared by the buddy page allocator and its users.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

endpackage

>>> rtl/core/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Binary buddy allocator; page tags and free-list links live in three
// synchronous memories with separate read and write ports, list heads in a small register file.
// ----------------------------------------------------------------------------
// sequence: alloc searches orders upward, unlinks a block and pushes each split-off
//   half; free checks the tag, then per merge reads the buddy tag and unlinks it,
//   and finally pushes the merged block; each order level takes a read-modify-write
//   of the link memories
// throughput: one request at a time; a finished result waits in the output register
// reset: a sweep over all ZONE_PAGES pages
//   writes the initial tags and links; no request is taken until it ends
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int ORDER_LEVELS = 11,
  parameter int ZONE_PAGES   = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [3:0]  order_i,
  input  logic [11:0] page_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [11:0] block_index_o,
  output logic [12:0] free_total_o
);

  localparam int AW = $clog2(ZONE_PAGES);
  localparam int LW = $clog2(ZONE_PAGES + 1);
  localparam int OW = $clog2(ORDER_LEVELS + 1);
  localparam int CW = ((LW > ORDER_LEVELS) ? LW : ORDER_LEVELS) + 2;
  localparam logic [LW-1:0] NIL     = LW'(ZONE_PAGES);
  localparam logic [CW-1:0] ZONE_C  = CW'(ZONE_PAGES);
  localparam logic [OW-1:0] TAG_NONE = '1;
  localparam logic [OW-1:0] TOP     = OW'(ORDER_LEVELS - 1);
  localparam logic [OW-1:0] LEVELS  = OW'(ORDER_LEVELS);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SRCH   = 4'd2;
  localparam logic [3:0] S_UNL_RD = 4'd3;
  localparam logic [3:0] S_UNL_WR = 4'd4;
  localparam logic [3:0] S_SPLIT  = 4'd5;
  localparam logic [3:0] S_PUSH_A = 4'd6;
  localparam logic [3:0] S_PUSH_B = 4'd7;
  localparam logic [3:0] S_FREE_RD = 4'd8;
  localparam logic [3:0] S_FREE_CK = 4'd9;
  localparam logic [3:0] S_MRG_RD = 4'd10;
  localparam logic [3:0] S_MRG_CK = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;
  localparam logic [3:0] S_UNL_CL = 4'd13;

  // memories
  logic [OW-1:0] tag_mem [ZONE_PAGES];
  logic [LW-1:0] nx_mem  [ZONE_PAGES];
  logic [LW-1:0] pv_mem  [ZONE_PAGES];
  logic [OW-1:0] tag_rd_q;
  logic [LW-1:0] nx_rd_q, pv_rd_q;

  logic          tag_we, nx_we, pv_we;
  logic [AW-1:0] tag_wa, nx_wa, pv_wa, tag_ra;
  logic [OW-1:0] tag_wd;
  logic [LW-1:0] nx_wd, pv_wd;

  // control and data registers
  logic [3:0]    state_q, state_d;
  logic [LW-1:0] head_q [ORDER_LEVELS];
  logic [LW-1:0] total_q, total_d;
  logic          op_q, op_d;
  logic [OW-1:0] ord_q, ord_d, cur_q, cur_d;
  logic [LW-1:0] idx_q, idx_d, blk_q, blk_d, push_q, push_d, h_q, h_d;
  logic [1:0]    res_st_q, res_st_d;
  logic [LW-1:0] res_idx_q, res_idx_d;
  logic          ov_q, ov_d;
  logic [1:0]    ost_q, ost_d;
  logic [LW-1:0] oidx_q, oidx_d, otot_q, otot_d;
  // reset sweep
  logic [LW-1:0] ip_q, ip_d, base_q, base_d, tail_q, tail_d;
  logic [OW-1:0] io_q, io_d;

  logic          hd_we;
  logic [OW-1:0] hd_wa;
  logic [LW-1:0] hd_wd;

  logic [CW-1:0] in_idx, in_size, ord_size, cur_bit, bud_c, isize, ibase;
  logic [LW-1:0] cur_head, bud;
  logic          in_bad_ord;

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = ov_q;
  assign status_o      = ost_q;
  assign block_index_o = 12'(oidx_q);
  assign free_total_o  = 13'(otot_q);

  // shared arithmetic
  assign in_idx     = CW'(page_index_i);
  assign in_size    = CW'(1) << order_i;
  assign in_bad_ord = ({1'b0, order_i} >= 5'(ORDER_LEVELS));
  assign ord_size   = CW'(1) << ord_q;
  assign cur_bit    = CW'(1) << cur_q;
  assign bud_c      = CW'(idx_q) ^ cur_bit;
  assign bud        = LW'(bud_c);
  assign cur_head   = (cur_q < LEVELS) ? head_q[cur_q[OW-1:0]] : NIL;
  assign isize      = CW'(1) << io_q;
  assign ibase      = CW'(base_q);

  // memory ports
  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    tag_rd_q <= tag_mem[tag_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    nx_rd_q <= nx_mem[blk_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    pv_rd_q <= pv_mem[blk_q[AW-1:0]];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    total_d = total_q;
    op_d = op_q; ord_d = ord_q; cur_d = cur_q;
    idx_d = idx_q; blk_d = blk_q; push_d = push_q; h_d = h_q;
    res_st_d = res_st_q; res_idx_d = res_idx_q;
    ov_d = ov_q; ost_d = ost_q; oidx_d = oidx_q; otot_d = otot_q;
    ip_d = ip_q; base_d = base_q; tail_d = tail_q; io_d = io_q;
    tag_we = 1'b0; tag_wa = '0; tag_wd = TAG_NONE; tag_ra = idx_q[AW-1:0];
    nx_we = 1'b0; nx_wa = '0; nx_wd = NIL;
    pv_we = 1'b0; pv_wa = '0; pv_wd = NIL;
    hd_we = 1'b0; hd_wa = cur_q; hd_wd = NIL;

    if (ov_q && out_ready_i) ov_d = 1'b0;

    case (state_q)
      // carve zone into largest blocks that fit, one page per cycle except while stepping down an order
      S_INIT: begin
        if (ip_q == NIL) begin
          state_d = S_IDLE;
        end else if (ip_q == base_q && (ZONE_C - ibase) < isize) begin
          io_d   = io_q - OW'(1);
          tail_d = NIL;
        end else if (ip_q == base_q) begin
          tag_we = 1'b1; tag_wa = ip_q[AW-1:0]; tag_wd = io_q;
          pv_we  = 1'b1; pv_wa = ip_q[AW-1:0]; pv_wd = tail_q;
          nx_we  = 1'b1; nx_wa = ip_q[AW-1:0];
          nx_wd  = (ZONE_C - ibase - isize >= isize) ? LW'(ibase + isize) : NIL;
          if (tail_q == NIL) begin
            hd_we = 1'b1; hd_wa = io_q; hd_wd = base_q;
          end
          tail_d = base_q;
          base_d = LW'(ibase + isize);
          ip_d   = ip_q + LW'(1);
        end else begin
          tag_we = 1'b1; tag_wa = ip_q[AW-1:0]; tag_wd = TAG_NONE;
          ip_d   = ip_q + LW'(1);
        end
      end
      // take a request
      S_IDLE: begin
        if (in_valid_i) begin
          op_d  = op_i;
          ord_d = OW'(order_i);
          cur_d = OW'(order_i);
          idx_d = LW'(in_idx);
          res_idx_d = '0;
          if (in_bad_ord) begin
            res_st_d = ST_BAD; state_d = S_FIN;
          end else if (!op_i) begin
            state_d = S_SRCH;
          end else if (in_idx >= ZONE_C || (in_idx & (in_size - CW'(1))) != '0 ||
                       (ZONE_C - in_idx) < in_size) begin
            res_st_d = ST_BAD; state_d = S_FIN;
          end else begin
            state_d = S_FREE_RD;
          end
        end
      end
      // lowest non-empty order at or above request
      S_SRCH: begin
        if (cur_q == LEVELS) begin
          res_st_d = ST_NOMEM; state_d = S_FIN;
        end else if (cur_head != NIL) begin
          blk_d = cur_head; state_d = S_UNL_RD;
        end else begin
          cur_d = cur_q + OW'(1);
        end
      end
      S_UNL_RD: state_d = S_UNL_WR;
      // unlink blk from list cur
      S_UNL_WR: begin
        if (pv_rd_q != NIL) begin
          nx_we = 1'b1; nx_wa = pv_rd_q[AW-1:0]; nx_wd = nx_rd_q;
        end else begin
          hd_we = 1'b1; hd_wa = cur_q; hd_wd = nx_rd_q;
        end
        if (nx_rd_q != NIL) begin
          pv_we = 1'b1; pv_wa = nx_rd_q[AW-1:0]; pv_wd = pv_rd_q;
        end
        tag_we = 1'b1; tag_wa = blk_q[AW-1:0]; tag_wd = TAG_NONE;
        state_d = S_UNL_CL;
      end
      // clear links of the unlinked block, after the neighbors are patched
      S_UNL_CL: begin
        nx_we = 1'b1; nx_wa = blk_q[AW-1:0]; nx_wd = NIL;
        pv_we = 1'b1; pv_wa = blk_q[AW-1:0]; pv_wd = NIL;
        if (!op_q) begin
          total_d   = (CW'(total_q) >= ord_size) ? LW'(CW'(total_q) - ord_size) : '0;
          res_idx_d = blk_q;
          state_d   = S_SPLIT;
        end else begin
          idx_d   = idx_q & blk_q;
          cur_d   = cur_q + OW'(1);
          state_d = S_MRG_RD;
        end
      end
      // split off upper halves
      S_SPLIT: begin
        if (cur_q > ord_q) begin
          cur_d   = cur_q - OW'(1);
          push_d  = LW'(CW'(blk_q) + (CW'(1) << (cur_q - OW'(1))));
          state_d = S_PUSH_A;
        end else begin
          res_st_d = ST_OK; state_d = S_FIN;
        end
      end
      // push onto front of list cur
      S_PUSH_A: begin
        h_d    = cur_head;
        nx_we  = 1'b1; nx_wa = push_q[AW-1:0]; nx_wd = cur_head;
        pv_we  = 1'b1; pv_wa = push_q[AW-1:0]; pv_wd = NIL;
        tag_we = 1'b1; tag_wa = push_q[AW-1:0]; tag_wd = cur_q;
        hd_we  = 1'b1; hd_wa = cur_q; hd_wd = push_q;
        if (op_q) total_d = LW'(CW'(total_q) + ord_size);
        state_d = S_PUSH_B;
      end
      S_PUSH_B: begin
        if (h_q != NIL) begin
          pv_we = 1'b1; pv_wa = h_q[AW-1:0]; pv_wd = push_q;
        end
        if (!op_q) begin
          state_d = S_SPLIT;
        end else begin
          res_st_d = ST_OK; res_idx_d = push_q; state_d = S_FIN;
        end
      end
      // double free checks
      S_FREE_RD: begin
        tag_ra  = idx_q[AW-1:0];
        state_d = S_FREE_CK;
      end
      S_FREE_CK: begin
        if (tag_rd_q != TAG_NONE || CW'(total_q) + ord_size > ZONE_C) begin
          res_st_d = ST_BAD; state_d = S_FIN;
        end else begin
          state_d = S_MRG_RD;
        end
      end
      // look at buddy tag
      S_MRG_RD: begin
        tag_ra = bud[AW-1:0];
        if (cur_q < TOP && bud_c < ZONE_C) begin
          state_d = S_MRG_CK;
        end else begin
          push_d = idx_q; state_d = S_PUSH_A;
        end
      end
      S_MRG_CK: begin
        if (tag_rd_q == cur_q) begin
          blk_d = bud; state_d = S_UNL_RD;
        end else begin
          push_d = idx_q; state_d = S_PUSH_A;
        end
      end
      // hand result to output register
      S_FIN: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1; ost_d = res_st_q; oidx_d = res_idx_q; otot_d = total_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // list head register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ORDER_LEVELS; i++) head_q[i] <= NIL;
    end else if (hd_we) begin
      head_q[hd_wa] <= hd_wd;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      total_q <= LW'(ZONE_PAGES);
      ov_q    <= 1'b0;
      ip_q    <= '0;
      base_q  <= '0;
      tail_q  <= NIL;
      io_q    <= TOP;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      ov_q    <= ov_d;
      ip_q    <= ip_d;
      base_q  <= base_d;
      tail_q  <= tail_d;
      io_q    <= io_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    op_q <= op_d; ord_q <= ord_d; cur_q <= cur_d;
    idx_q <= idx_d; blk_q <= blk_d; push_q <= push_d; h_q <= h_d;
    res_st_q <= res_st_d; res_idx_q <= res_idx_d;
    ost_q <= ost_d; oidx_q <= oidx_d; otot_q <= otot_d;
  end

endmodule
